[rtl/lr_pkg.sv]
// shared types and constants for the line rasterizer
package lr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEC_BITS   = COORD_BITS + 3;
    localparam int INC_BITS   = COORD_BITS + 2;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic   func;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_in_req;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last_pixel;
    } t_out_req;

    typedef struct packed {
        t_coord                      cur_x;
        t_coord                      cur_y;
        t_coord                      stop_x;
        t_coord                      stop_y;
        logic signed [DEC_BITS-1:0]  decision;
        logic signed [INC_BITS-1:0]  inc_hold;
        logic signed [INC_BITS-1:0]  inc_diag;
        logic                        steep_mode;
        logic                        y_falling;
        logic                        active;
    } t_line_state;

endpackage

[rtl/line_rasterizer_core.sv]
// top level of the bresenham line rasterizer
//
// integer bresenham line generator. a start request (func = 0) takes two
// endpoints, orders them so that x never decreases and returns the first
// pixel. each advance request (func = 1) returns the next pixel, with
// last_pixel set on the line's final endpoint; an advance with no line
// active is taken and returns nothing. a start drops any line in progress.
// shallow lines (|dy| <= dx) step x every pixel and end on x, steep lines
// step y every pixel and end on y. a single point gives one pixel with
// last_pixel set. throughput is one request per clock while the skid stage
// is free: line state is updated through the step unit (one add and
// compare on an advance) and the result lands in an output register. a skid
// stage behind the output register keeps the input open for one more
// request while the sink stalls; the input stalls only when both are full.
module line_rasterizer_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lr_pkg::t_in_req  i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lr_pkg::t_out_req o_out_req
);

    // line state registers
    lr_pkg::t_line_state r_state, n_state;
    lr_pkg::t_out_req    step_result;
    logic                step_result_valid;
    logic                in_accept;
    logic                buf_room;

    assign o_in_ready = buf_room;
    assign in_accept  = i_in_valid && buf_room;

    // setup or advance from the current state
    lr_step u_step (
        .i_state        (r_state),
        .i_req          (i_in_req),
        .o_state        (n_state),
        .o_result       (step_result),
        .o_result_valid (step_result_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // result register plus skid entry
    lr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept && step_result_valid),
        .i_data  (step_result),
        .o_room  (buf_room),
        .o_valid (o_out_valid),
        .o_data  (o_out_req),
        .i_ready (i_out_ready)
    );

endmodule

[rtl/lr_step.sv]
// line setup and single pixel advance, combinational
module lr_step (
    input  lr_pkg::t_line_state i_state,
    input  lr_pkg::t_in_req     i_req,
    output lr_pkg::t_line_state o_state,
    output lr_pkg::t_out_req    o_result,
    output logic                o_result_valid
);

    localparam int CB = lr_pkg::COORD_BITS;
    localparam int DB = lr_pkg::DEC_BITS;
    localparam int IB = lr_pkg::INC_BITS;

    logic                 swap;
    lr_pkg::t_coord       x0, y0, x1, y1, dx, ady;
    logic                 falling, steep;
    logic signed [DB-1:0] dx_s, ady_s;
    logic signed [IB-1:0] dx2, ady2;
    logic signed [DB-1:0] hold_ext, diag_ext;
    lr_pkg::t_coord       y_stepped, x_next;
    logic                 last;

    // setup datapath
    always_comb begin
        swap    = i_req.x_end < i_req.x_start;
        x0      = swap ? i_req.x_end   : i_req.x_start;
        y0      = swap ? i_req.y_end   : i_req.y_start;
        x1      = swap ? i_req.x_start : i_req.x_end;
        y1      = swap ? i_req.y_start : i_req.y_end;
        dx      = x1 - x0;
        falling = y1 < y0;
        ady     = falling ? (y0 - y1) : (y1 - y0);
        steep   = ady > dx;
        dx_s    = signed'({{(DB-CB){1'b0}}, dx});
        ady_s   = signed'({{(DB-CB){1'b0}}, ady});
        dx2     = signed'({{(IB-CB-1){1'b0}}, dx, 1'b0});
        ady2    = signed'({{(IB-CB-1){1'b0}}, ady, 1'b0});
    end

    // advance datapath
    always_comb begin
        hold_ext  = {{(DB-IB){i_state.inc_hold[IB-1]}}, i_state.inc_hold};
        diag_ext  = {{(DB-IB){i_state.inc_diag[IB-1]}}, i_state.inc_diag};
        y_stepped = i_state.y_falling ? (i_state.cur_y - CB'(1)) : (i_state.cur_y + CB'(1));
        x_next    = i_state.cur_x + CB'(1);
    end

    always_comb begin
        o_state        = i_state;
        last           = 1'b0;
        o_result_valid = 1'b1;
        if (i_req.func == lr_pkg::FUNC_START) begin
            o_state.steep_mode = steep;
            o_state.y_falling  = falling;
            if (steep) begin
                o_state.decision = ady_s - (dx_s <<< 1);
                o_state.inc_hold = -dx2;
            end else begin
                o_state.decision = (ady_s <<< 1) - dx_s;
                o_state.inc_hold = ady2;
            end
            o_state.inc_diag = ady2 - dx2;
            o_state.cur_x    = x0;
            o_state.cur_y    = y0;
            o_state.stop_x   = x1;
            o_state.stop_y   = y1;
            last             = (dx == '0) && (ady == '0);
            o_state.active   = !last;
        end else if (!i_state.active) begin
            o_result_valid = 1'b0;
        end else begin
            if (i_state.steep_mode) begin
                if (i_state.decision > 0) begin
                    o_state.decision = i_state.decision + hold_ext;
                end else begin
                    o_state.decision = i_state.decision + diag_ext;
                    o_state.cur_x    = x_next;
                end
                o_state.cur_y = y_stepped;
                last          = y_stepped == i_state.stop_y;
            end else begin
                if (i_state.decision <= 0) begin
                    o_state.decision = i_state.decision + hold_ext;
                end else begin
                    o_state.decision = i_state.decision + diag_ext;
                    o_state.cur_y    = y_stepped;
                end
                o_state.cur_x = x_next;
                last          = x_next == i_state.stop_x;
            end
            if (last) begin
                o_state.active = 1'b0;
            end
        end
        o_result.pixel_x    = o_state.cur_x;
        o_result.pixel_y    = o_state.cur_y;
        o_result.last_pixel = last;
    end

endmodule

[rtl/lr_out_buf.sv]
// two entry output register with skid stage
module lr_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lr_pkg::t_out_req i_data,
    output logic             o_room,
    output logic             o_valid,
    output lr_pkg::t_out_req o_data,
    input  logic             i_ready
);

    logic             r_out_valid, r_skid_valid;
    lr_pkg::t_out_req r_out_data, r_skid_data;
    logic             out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_room   = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
                r_out_data  <= i_data;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end

endmodule

[rtl/lr_checker.sv]
// port level checks for the line rasterizer, bound to the top level
module lr_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input lr_pkg::t_in_req  i_in_req,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input lr_pkg::t_out_req o_out_req
);

    logic start_acc;
    assign start_acc = i_in_valid && o_in_ready && (i_in_req.func == lr_pkg::FUNC_START);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("stalled result changed");

    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_acc |=> o_out_valid)
        else $error("start request gave no result");

    a_point_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_acc && (i_in_req.x_start == i_in_req.x_end)
            && (i_in_req.y_start == i_in_req.y_end)
            && (!o_out_valid || i_out_ready)
        |=> o_out_req.last_pixel && (o_out_req.pixel_x == $past(i_in_req.x_start)))
        else $error("single point not marked last");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (.*);
